@@ design/prr_pkg.sv @@
// Shared constants, types and state encoding of the polyphase rational resampler.
package prr_pkg;

    localparam int UP_FACTOR      = 24;
    localparam int DOWN_FACTOR    = 25;
    localparam int TAPS_PER_PHASE = 32;

    localparam int COEF_DEPTH = UP_FACTOR * TAPS_PER_PHASE;
    localparam int COEF_AW    = $clog2(COEF_DEPTH);
    localparam int TAP_W      = (TAPS_PER_PHASE > 1) ? $clog2(TAPS_PER_PHASE) : 1;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 18;
    localparam int INDEX_W  = 10;
    localparam int OFS_W    = 8;
    localparam int PROD_W   = SAMPLE_W + COEF_W;
    localparam int ACC_W    = PROD_W + $clog2(TAPS_PER_PHASE) + 1;
    localparam int FRAC_W   = 15;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 16;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_COEF   = 1'b1;

    localparam logic signed [ACC_W-1:0] SUM_HI = ACC_W'(64'sd32767 <<< FRAC_W);
    localparam logic signed [ACC_W-1:0] SUM_LO = ACC_W'(-64'sd32768 <<< FRAC_W);
    localparam logic signed [ACC_W-1:0] RND_POS = ACC_W'(16384);
    localparam logic signed [ACC_W-1:0] RND_NEG = ACC_W'(16383);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic clear;
        logic enable;
    } mac_ctrl_t;

endpackage

@@ design/prr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module prr_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/prr_mac.sv @@
// Shared multiply-accumulate unit with round-half-away and 16-bit saturation.
module prr_mac (
    input  logic                            clk,
    input  logic                            rst_n,
    input  prr_pkg::mac_ctrl_t              ctrl,
    input  logic [prr_pkg::COEF_W-1:0]      coef,
    input  logic signed [prr_pkg::SAMPLE_W-1:0] sample,
    output logic signed [prr_pkg::SAMPLE_W-1:0] result,
    output logic                            clipped
);
    import prr_pkg::*;

    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  rounded;

    assign prod = $signed(coef) * sample;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (ctrl.enable)
        begin
            acc_next = acc_reg + ACC_W'(prod);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    // Adding one less than a half before the floor shift rounds negative
    // sums away from zero, the same as rounding the magnitude.
    assign rounded = (acc_reg + (acc_reg[ACC_W-1] ? RND_NEG : RND_POS)) >>> FRAC_W;

    always_comb
    begin
        priority if (acc_reg > SUM_HI)
        begin
            result  = 16'sh7FFF;
            clipped = 1'b1;
        end
        else if (acc_reg < SUM_LO)
        begin
            result  = 16'sh8000;
            clipped = 1'b1;
        end
        else
        begin
            result  = rounded[SAMPLE_W-1:0];
            clipped = 1'b0;
        end
    end

endmodule

@@ design/polyphase_rational_resampler_core.sv @@
// Top level of the polyphase rational resampler: sequencer, history line and output register.
//
// Each input beat is either a coefficient write (tuser = 1) or an audio sample (tuser = 0).
// A coefficient write and a sample that yields no output position leave the block idle.
// A sample that yields an output starts a filter pass through the run, drain and finish
// states, in which one multiply-accumulate unit walks the taps of the selected phase, fed
// by one read port of the coefficient RAM. The block takes no new beat during the pass.
// The finished sample waits in an output register, so the next input is taken while it is
// still pending. Coefficients must be written before samples that use them are sent.
module polyphase_rational_resampler_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // sample_in [15:0], coef_index [25:16], coef_value [43:26], zeros above
    input  logic [prr_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // req_type
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // sample_out [15:0]
    output logic [prr_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // clipped
    output logic                              m_axis_tuser
);
    import prr_pkg::*;

    state_t state_reg, state_next;

    logic signed [SAMPLE_W-1:0] hist_reg [TAPS_PER_PHASE];
    logic [TAP_W-1:0]   k_reg, k_next;
    logic [COEF_AW-1:0] base_reg, base_next;
    logic [OFS_W-1:0]   offset_reg, offset_next;
    logic               v1_reg, v1_next;
    logic signed [SAMPLE_W-1:0] h1_reg, h1_next;
    logic               out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0] out_data_reg, out_data_next;
    logic               out_clip_reg, out_clip_next;

    logic               in_fire;
    logic               is_sample;
    logic               has_output;
    logic [OFS_W:0]     ofs_sum;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [INDEX_W-1:0] coef_index;
    logic [COEF_W-1:0]  coef_value;
    logic               ram_we;
    logic               ram_re;
    logic [COEF_AW-1:0] ram_raddr;
    logic [COEF_W-1:0]  ram_rdata;
    mac_ctrl_t          mac_ctrl;
    logic signed [SAMPLE_W-1:0] mac_result;
    logic               mac_clipped;

    assign sample_in  = s_axis_tdata[15:0];
    assign coef_index = s_axis_tdata[25:16];
    assign coef_value = s_axis_tdata[43:26];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign is_sample     = (s_axis_tuser == REQ_SAMPLE);
    assign has_output    = (offset_reg < OFS_W'(UP_FACTOR));

    assign ram_we    = in_fire && (s_axis_tuser == REQ_COEF)
                       && ({1'b0, coef_index} < (INDEX_W+1)'(COEF_DEPTH));
    assign ram_re    = (state_reg == ST_RUN);
    assign ram_raddr = base_reg + COEF_AW'(k_reg);

    prr_ram #(
        .WIDTH(COEF_W),
        .DEPTH(COEF_DEPTH)
    ) u_coef_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(coef_index[COEF_AW-1:0]),
        .wdata(coef_value),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign mac_ctrl.clear  = in_fire && is_sample;
    assign mac_ctrl.enable = v1_reg;

    prr_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .coef   (ram_rdata),
        .sample (h1_reg),
        .result (mac_result),
        .clipped(mac_clipped)
    );

    // The history line shifts newest-first on every accepted audio sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAPS_PER_PHASE; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (in_fire && is_sample)
        begin
            for (int i = TAPS_PER_PHASE - 1; i > 0; i--)
            begin
                hist_reg[i] <= hist_reg[i-1];
            end
            hist_reg[0] <= sample_in;
        end
    end

    always_comb
    begin
        ofs_sum = {1'b0, offset_reg} + (has_output ? (OFS_W+1)'(DOWN_FACTOR) : '0);
    end

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        base_next      = base_reg;
        offset_next    = offset_reg;
        v1_next        = 1'b0;
        h1_next        = h1_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_clip_next  = out_clip_reg;

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && is_sample)
                begin
                    offset_next = (ofs_sum >= (OFS_W+1)'(UP_FACTOR))
                                  ? OFS_W'(ofs_sum - (OFS_W+1)'(UP_FACTOR)) : '0;
                    if (has_output)
                    begin
                        base_next  = COEF_AW'(offset_reg * TAPS_PER_PHASE);
                        k_next     = '0;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                v1_next = 1'b1;
                h1_next = hist_reg[k_reg];
                k_next  = k_reg + 1'b1;
                if (k_reg == TAP_W'(TAPS_PER_PHASE - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = mac_result;
                    out_clip_next  = mac_clipped;
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            offset_reg    <= '0;
            v1_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            offset_reg    <= offset_next;
            v1_reg        <= v1_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg     <= base_next;
        h1_reg       <= h1_next;
        out_data_reg <= out_data_next;
        out_clip_reg <= out_clip_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_clip_reg;

    a_offset_bound: assert property (@(posedge clk) disable iff (!rst_n)
        offset_reg < OFS_W'(DOWN_FACTOR))
        else $error("output offset left its range");

    a_skip_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && is_sample && !has_output) |=> (state_reg == ST_IDLE))
        else $error("sample without output position started a filter pass");

    a_run_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && $past(state_reg) != ST_RUN) |-> (k_reg == '0))
        else $error("filter pass did not start at the first tap");

    a_finish_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |-> !v1_reg)
        else $error("result taken while a product was still in flight");

    a_no_lost_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_valid_reg && !m_axis_tready)
        |=> (state_reg == ST_FINISH))
        else $error("pending result overwritten");

endmodule
